>>> src/tpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types and constants of the topographic pixel classifier
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int unsigned ThrWidth  = 31;
   localparam int unsigned CsrIdxW   = 2;
   localparam int unsigned CsrDataW  = 32;
   localparam int unsigned PixelW    = 192;
   localparam int unsigned RspDataW  = 8;

   localparam logic [ThrWidth-1:0] GradMagThrReset = 31'd91750;
   localparam logic [ThrWidth-1:0] EigenThrReset   = 31'd65536;
   localparam logic [ThrWidth-1:0] ProjThrReset    = 31'd0;

   localparam logic [CsrIdxW-1:0] CsrGradMagThr = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrEigenThr   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrProjThr    = 2'd2;

   typedef enum logic [3:0] {
      LBL_PEAK           = 4'd0,
      LBL_PIT            = 4'd1,
      LBL_RIDGE_SADDLE   = 4'd2,
      LBL_RAVINE_SADDLE  = 4'd3,
      LBL_RIDGE          = 4'd4,
      LBL_RAVINE         = 4'd5,
      LBL_FLAT           = 4'd6,
      LBL_SLOPE_HILL     = 4'd7,
      LBL_CONVEX         = 4'd8,
      LBL_CONCAVE        = 4'd9,
      LBL_CONVEX_SADDLE  = 4'd10,
      LBL_CONCAVE_SADDLE = 4'd11,
      LBL_UNKNOWN        = 4'd12
   } surface_label_type;

   // packed so that grad_x lands in the lowest bits
   typedef struct packed {
      logic signed [15:0] vec_second_y;
      logic signed [15:0] vec_second_x;
      logic signed [15:0] vec_first_y;
      logic signed [15:0] vec_first_x;
      logic signed [31:0] eig_second;
      logic signed [31:0] eig_first;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_x;
   } pixel_type;

   typedef struct packed {
      logic n1;        // first eigenvalue below -threshold
      logic n2;
      logic q1;        // first eigenvalue above +threshold
      logic q2;
      logic e1_neg;
      logic e1_pos;
      logic e2_neg;
      logic e2_pos;
      logic sum_neg;   // eigenvalue sum below zero
   } eig_flags_type;

   typedef struct packed {
      logic [62:0]        sq_x;
      logic [62:0]        sq_y;
      logic [61:0]        thr_sq;
      logic signed [47:0] p1_x;
      logic signed [47:0] p1_y;
      logic signed [47:0] p2_x;
      logic signed [47:0] p2_y;
      eig_flags_type      eig;
   } mult_type;

   typedef struct packed {
      logic low_grad;   // gradient magnitude under the limit
      logic lo1;
      logic lo2;
      eig_flags_type eig;
   } decide_type;

endpackage

>>> src/topographic_pixel_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topographic_pixel_classifier
// per-pixel topographic label from gradient, hessian eigenvalues and vectors
// ----------------------------------------------------------------------------
// usage
//   req_*  : one pixel per beat, 192-bit tdata (gradient, eigenvalues, vectors)
//   rsp_*  : one label per beat, 4-bit code in the low bits of 8-bit tdata
//   csr_*  : threshold writes, index 0 grad magnitude, 1 eigen, 2 projection;
//            other indexes are dropped; csr_ready is always high
//   throughput: one pixel per cycle unless a held label stalls it, set by the
//   four-stage pipeline with a 32x32 multiplier stage feeding the sums
//   stages: products and eigen flags, sums, threshold compares, label
//   reset: pipeline and skid emptied, thresholds back to 1.4, 1.0 and 0
//   stall: when rsp_tready is low with a label waiting the whole pipeline
//   holds; req_tready comes from a registered skid slot so one more beat is
//   taken and parked, then req_tready drops until the pipeline moves again
//   thresholds are only to be written while no pixel is in flight
// ----------------------------------------------------------------------------
module topographic_pixel_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // grad_x, grad_y, eig_first, eig_second, vec_first_x, vec_first_y,
   // vec_second_x, vec_second_y
   input  logic [tpc_pkg::PixelW-1:0]          req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // surface_label, zero padded
   output logic [tpc_pkg::RspDataW-1:0]        rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tpc_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [tpc_pkg::CsrDataW-1:0]        csr_data
);
   import tpc_pkg::*;

   // threshold registers
   logic [ThrWidth-1:0] grad_mag_thr_ff, grad_mag_thr_in;
   logic [ThrWidth-1:0] eigen_thr_ff, eigen_thr_in;
   logic [ThrWidth-1:0] proj_thr_ff, proj_thr_in;

   // pipeline advances unless a finished label is blocked
   logic              en;
   logic              s0_valid, s1_valid, s3_valid;
   pixel_type         s0_pixel;
   mult_type          s1_data;
   decide_type        s3_data;
   surface_label_type label;

   assign csr_ready = 1'b1;

   always_comb begin
      grad_mag_thr_in = grad_mag_thr_ff;
      eigen_thr_in    = eigen_thr_ff;
      proj_thr_in     = proj_thr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrGradMagThr: grad_mag_thr_in = csr_data[ThrWidth-1:0];
            CsrEigenThr:   eigen_thr_in    = csr_data[ThrWidth-1:0];
            CsrProjThr:    proj_thr_in     = csr_data[ThrWidth-1:0];
            default: ;     // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_mag_thr_ff <= GradMagThrReset;
         eigen_thr_ff    <= EigenThrReset;
         proj_thr_ff     <= ProjThrReset;
      end else begin
         grad_mag_thr_ff <= grad_mag_thr_in;
         eigen_thr_ff    <= eigen_thr_in;
         proj_thr_ff     <= proj_thr_in;
      end
   end

   assign en = ~rsp_tvalid | rsp_tready;

   tpc_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pixel  (pixel_type'(req_tdata)),
      .out_valid  (s0_valid),
      .out_pixel  (s0_pixel)
   );

   // stage one: multipliers
   tpc_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (s0_valid),
      .in_pixel     (s0_pixel),
      .grad_mag_thr (grad_mag_thr_ff),
      .eigen_thr    (eigen_thr_ff),
      .out_valid    (s1_valid),
      .out_data     (s1_data)
   );

   // stages two and three: sums and compares
   tpc_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .proj_thr  (proj_thr_ff),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   // stage four: label into the output register
   tpc_label u_label (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_label (label)
   );

   assign rsp_tdata = {4'b0000, label};

endmodule

>>> src/tpc_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_skid
// input skid buffer, keeps req_tready off the downstream stall path
// ----------------------------------------------------------------------------
module tpc_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tpc_pkg::pixel_type    req_pixel,
   output logic                  out_valid,
   output tpc_pkg::pixel_type    out_pixel
);
   import tpc_pkg::*;

   logic      hold_valid_ff, hold_valid_in;
   pixel_type hold_pixel_ff, hold_pixel_in;
   logic      req_fire;

   assign req_tready = ~hold_valid_ff;
   assign req_fire   = req_tvalid & req_tready;

   assign out_valid = hold_valid_ff | req_fire;
   assign out_pixel = hold_valid_ff ? hold_pixel_ff : req_pixel;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_pixel_in = hold_pixel_ff;
      if (hold_valid_ff) begin
         if (en) hold_valid_in = 1'b0;
      end else if (req_fire && !en) begin
         hold_valid_in = 1'b1;
         hold_pixel_in = req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) hold_valid_ff <= 1'b0;
      else       hold_valid_ff <= hold_valid_in;
      hold_pixel_ff <= hold_pixel_in;
   end

endmodule

>>> src/tpc_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_mult
// stage one: squares, projection products and eigenvalue flags
// ----------------------------------------------------------------------------
module tpc_mult (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  tpc_pkg::pixel_type                  in_pixel,
   input  logic [tpc_pkg::ThrWidth-1:0]        grad_mag_thr,
   input  logic [tpc_pkg::ThrWidth-1:0]        eigen_thr,
   output logic                                out_valid,
   output tpc_pkg::mult_type                   out_data
);
   import tpc_pkg::*;

   logic          valid_ff;
   mult_type      data_ff, data_in;

   logic signed [63:0] sq_x, sq_y;
   logic [61:0]        thr_sq;
   logic signed [47:0] p1_x, p1_y, p2_x, p2_y;
   logic signed [32:0] e1_w, e2_w, tev_w, esum;

   assign sq_x   = in_pixel.grad_x * in_pixel.grad_x;
   assign sq_y   = in_pixel.grad_y * in_pixel.grad_y;
   assign thr_sq = grad_mag_thr * grad_mag_thr;
   assign p1_x   = in_pixel.grad_x * in_pixel.vec_first_x;
   assign p1_y   = in_pixel.grad_y * in_pixel.vec_first_y;
   assign p2_x   = in_pixel.grad_x * in_pixel.vec_second_x;
   assign p2_y   = in_pixel.grad_y * in_pixel.vec_second_y;

   assign e1_w  = {in_pixel.eig_first[31], in_pixel.eig_first};
   assign e2_w  = {in_pixel.eig_second[31], in_pixel.eig_second};
   assign tev_w = {2'b00, eigen_thr};
   assign esum  = e1_w + e2_w;

   always_comb begin
      data_in.sq_x           = sq_x[62:0];
      data_in.sq_y           = sq_y[62:0];
      data_in.thr_sq         = thr_sq;
      data_in.p1_x           = p1_x;
      data_in.p1_y           = p1_y;
      data_in.p2_x           = p2_x;
      data_in.p2_y           = p2_y;
      data_in.eig.n1         = e1_w < -tev_w;
      data_in.eig.n2         = e2_w < -tev_w;
      data_in.eig.q1         = e1_w > tev_w;
      data_in.eig.q2         = e2_w > tev_w;
      data_in.eig.e1_neg     = in_pixel.eig_first[31];
      data_in.eig.e1_pos     = ~in_pixel.eig_first[31] & (|in_pixel.eig_first);
      data_in.eig.e2_neg     = in_pixel.eig_second[31];
      data_in.eig.e2_pos     = ~in_pixel.eig_second[31] & (|in_pixel.eig_second);
      data_in.eig.sum_neg    = esum[32];
   end

   always_ff @(posedge clock) begin
      if (reset)   valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
      if (en) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/tpc_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_reduce
// stages two and three: magnitude and projection sums, then threshold compares
// ----------------------------------------------------------------------------
module tpc_reduce (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  tpc_pkg::mult_type                   in_data,
   input  logic [tpc_pkg::ThrWidth-1:0]        proj_thr,
   output logic                                out_valid,
   output tpc_pkg::decide_type                 out_data
);
   import tpc_pkg::*;

   // stage two
   logic               sum_valid_ff;
   logic [63:0]        mag2_ff, mag2_in;
   logic [61:0]        thr_sq_ff;
   logic signed [48:0] p1_ff, p1_in, p2_ff, p2_in;
   eig_flags_type      eig_ff;

   // stage three
   logic               cmp_valid_ff;
   decide_type         cmp_ff, cmp_in;
   logic signed [48:0] tge;

   assign mag2_in = {1'b0, in_data.sq_x} + {1'b0, in_data.sq_y};
   assign p1_in   = {in_data.p1_x[47], in_data.p1_x} + {in_data.p1_y[47], in_data.p1_y};
   assign p2_in   = {in_data.p2_x[47], in_data.p2_x} + {in_data.p2_y[47], in_data.p2_y};

   always_ff @(posedge clock) begin
      if (reset)   sum_valid_ff <= 1'b0;
      else if (en) sum_valid_ff <= in_valid;
      if (en) begin
         mag2_ff   <= mag2_in;
         thr_sq_ff <= in_data.thr_sq;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         eig_ff    <= in_data.eig;
      end
   end

   // |p| < t written as -t < p < t
   assign tge = {4'b0000, proj_thr, 14'b0};

   always_comb begin
      cmp_in.low_grad = mag2_ff < {2'b00, thr_sq_ff};
      cmp_in.lo1      = (p1_ff < tge) && (p1_ff > -tge);
      cmp_in.lo2      = (p2_ff < tge) && (p2_ff > -tge);
      cmp_in.eig      = eig_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)   cmp_valid_ff <= 1'b0;
      else if (en) cmp_valid_ff <= sum_valid_ff;
      if (en) cmp_ff <= cmp_in;
   end

   assign out_valid = cmp_valid_ff;
   assign out_data  = cmp_ff;

endmodule

>>> src/tpc_label.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_label
// stage four: label decision into the output register
// ----------------------------------------------------------------------------
module tpc_label (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  tpc_pkg::decide_type                 in_data,
   output logic                                out_valid,
   output tpc_pkg::surface_label_type          out_label
);
   import tpc_pkg::*;

   logic              valid_ff;
   surface_label_type label_ff, label_in;
   logic low_grad, big, n1, n2, q1, q2, f1, f2, lo1, lo2, opp;
   eig_flags_type e;

   assign e        = in_data.eig;
   assign low_grad = in_data.low_grad;
   assign big      = ~in_data.low_grad;
   assign lo1      = in_data.lo1;
   assign lo2      = in_data.lo2;
   assign n1       = e.n1;
   assign n2       = e.n2;
   assign q1       = e.q1;
   assign q2       = e.q2;
   assign f1       = ~e.n1 & ~e.q1;
   assign f2       = ~e.n2 & ~e.q2;
   assign opp      = (e.e1_neg & e.e2_pos) | (e.e1_pos & e.e2_neg);

   always_comb begin
      label_in = LBL_UNKNOWN;
      if (low_grad && n1 && n2) begin
         label_in = LBL_PEAK;
      end else if (low_grad && q1 && q2) begin
         label_in = LBL_PIT;
      end else if (low_grad && opp) begin
         label_in = e.sum_neg ? LBL_RIDGE_SADDLE : LBL_RAVINE_SADDLE;
      end else if ((big && n1 && lo1) || (big && n2 && lo2) ||
                   (low_grad && n1 && f2) || (low_grad && f1 && n2)) begin
         label_in = LBL_RIDGE;
      end else if ((big && q1 && lo1) || (big && q2 && lo2) ||
                   (low_grad && q1 && f2) || (low_grad && f1 && q2)) begin
         label_in = LBL_RAVINE;
      end else if (low_grad && f1 && f2) begin
         label_in = LBL_FLAT;
      end else if ((!lo1 && !lo2) || (!lo1 && f2) || (!lo2 && f1) ||
                   (big && f1 && f2)) begin
         // hill family
         if (f1 && f2) begin
            label_in = LBL_SLOPE_HILL;
         end else if ((e.e1_pos && !e.e2_neg) || (!e.e1_neg && e.e2_pos)) begin
            label_in = LBL_CONVEX;
         end else if ((e.e1_neg && !e.e2_pos) || (!e.e1_pos && e.e2_neg)) begin
            label_in = LBL_CONCAVE;
         end else if (opp) begin
            label_in = e.sum_neg ? LBL_CONVEX_SADDLE : LBL_CONCAVE_SADDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
      if (en) label_ff <= label_in;
   end

   assign out_valid = valid_ff;
   assign out_label = label_ff;

endmodule

>>> bench/tb_topographic_pixel_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_topographic_pixel_classifier
// self-checking bench for the per-pixel topographic labeler
// ----------------------------------------------------------------------------
// a directed table walks the label classes and the threshold edges under the
// reset thresholds; then a series of threshold settings (all zero, full
// scale, reset values with the unused top bit set, random) each get a batch
// of random pixels. every accepted pixel's label (table or local predictor) is
// queued; every label beat is compared with the oldest queued label. the
// sender bursts and pauses, the sink stalls on its own pattern, and once the
// sink holds off long enough for the pipeline and its skid slot to fill.
// ----------------------------------------------------------------------------
module tb_topographic_pixel_classifier;

   import tpc_pkg::*;

   localparam int DirRows     = 22;
   localparam int NumPhases   = 12;
   localparam int PhaseItems  = 75;
   localparam int HoldPhase   = 3;
   localparam int HoldCycles  = 80;
   localparam int DrainCycles = 8;

   // no register sits at this index, writes to it must be dropped
   localparam logic [CsrIdxW-1:0] CsrUnused = 2'd3;

   // Q16.16 and Q1.14 shorthands for the directed table
   localparam int One  = 65536;
   localparam int Two  = 131072;
   localparam int Vec  = 16384;
   localparam logic signed [31:0] GMin = 32'sh8000_0000;
   localparam logic signed [31:0] GMax = 32'sh7FFF_FFFF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [PixelW-1:0]     req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CsrIdxW-1:0]    csr_index  = '0;
   logic [CsrDataW-1:0]   csr_data   = '0;

   // local copy of the thresholds, kept in step with every csr write
   logic [ThrWidth-1:0]   mag_thr  = GradMagThrReset;
   logic [ThrWidth-1:0]   eig_thr  = EigenThrReset;
   logic [ThrWidth-1:0]   proj_thr = ProjThrReset;

   surface_label_type     pending_labels [$];
   int unsigned           mismatch_count = 0;
   int unsigned           pixels_sent    = 0;
   int unsigned           labels_checked = 0;
   int unsigned           label_hits [0:12];

   // sender pacing
   int unsigned           burst_left = 0;
   int unsigned           max_gap    = 4;

   // raised by the stimulus, cleared by the sink once the hold-off is over
   bit                    long_hold_req = 1'b0;

   always #2 clock = ~clock;

   topographic_pixel_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // label predictor, exact 64-bit integer arithmetic
   // -------------------------------------------------------------------------
   function automatic surface_label_type classify_pixel(input pixel_type px);
      longint gx, gy, e1, e2, v1x, v1y, v2x, v2y;
      longint tev, tge, d1, d2, p1, p2, a1, a2;
      longint unsigned mag_sq, thr_wide, thr_sq;
      bit small_g, steep, n1, n2, q1, q2, f1, f2, opp, lo1, lo2;
      gx  = $signed(px.grad_x);
      gy  = $signed(px.grad_y);
      e1  = $signed(px.eig_first);
      e2  = $signed(px.eig_second);
      v1x = $signed(px.vec_first_x);
      v1y = $signed(px.vec_first_y);
      v2x = $signed(px.vec_second_x);
      v2y = $signed(px.vec_second_y);

      // two full-scale squares sum to exactly 2^63, fine as unsigned
      mag_sq   = gx * gx + gy * gy;
      thr_wide = mag_thr;
      thr_sq   = thr_wide * thr_wide;
      tev      = eig_thr;
      tge      = proj_thr;
      tge      = tge <<< 14;   // Q16.16 threshold lined up with the Q.30 dot product

      d1 = gx * v1x + gy * v1y;
      d2 = gx * v2x + gy * v2y;
      p1 = (d1 < 0) ? -d1 : d1;
      p2 = (d2 < 0) ? -d2 : d2;
      a1 = (e1 < 0) ? -e1 : e1;
      a2 = (e2 < 0) ? -e2 : e2;

      small_g = mag_sq < thr_sq;
      steep   = !small_g;
      n1  = e1 < -tev;
      n2  = e2 < -tev;
      q1  = e1 > tev;
      q2  = e2 > tev;
      f1  = a1 <= tev;
      f2  = a2 <= tev;
      opp = (e1 < 0 && e2 > 0) || (e1 > 0 && e2 < 0);
      lo1 = p1 < tge;
      lo2 = p2 < tge;

      if (small_g && n1 && n2) return LBL_PEAK;
      if (small_g && q1 && q2) return LBL_PIT;
      if (small_g && opp) return (e1 + e2 < 0) ? LBL_RIDGE_SADDLE : LBL_RAVINE_SADDLE;
      if ((steep && n1 && lo1) || (steep && n2 && lo2) ||
          (small_g && n1 && f2) || (small_g && f1 && n2)) return LBL_RIDGE;
      if ((steep && q1 && lo1) || (steep && q2 && lo2) ||
          (small_g && q1 && f2) || (small_g && f1 && q2)) return LBL_RAVINE;
      if (small_g && f1 && f2) return LBL_FLAT;
      if ((!lo1 && !lo2) || (!lo1 && f2) || (!lo2 && f1) || (steep && f1 && f2)) begin
         if (f1 && f2) return LBL_SLOPE_HILL;
         if ((e1 > 0 && e2 >= 0) || (e1 >= 0 && e2 > 0)) return LBL_CONVEX;
         if ((e1 < 0 && e2 <= 0) || (e1 <= 0 && e2 < 0)) return LBL_CONCAVE;
         if (opp) return (e1 + e2 < 0) ? LBL_CONVEX_SADDLE : LBL_CONCAVE_SADDLE;
         // hill with no sign match falls back to unknown
         return LBL_UNKNOWN;
      end
      return LBL_UNKNOWN;
   endfunction

   // -------------------------------------------------------------------------
   // random field pickers; gradients and eigenvalues biased toward the current thresholds
   // -------------------------------------------------------------------------
   function automatic logic [31:0] pick_near(input longint unsigned span);
      longint offset;
      if (span > 64'h7FFF_FFFE) return $urandom;
      offset = longint'($urandom_range(32'(2 * span))) - longint'(span);
      return offset[31:0];
   endfunction

   function automatic logic [31:0] pick_eigen();
      longint b;
      case ($urandom_range(5))
         0: return '0;
         1: begin
            // right on the eigen threshold or one lsb beyond, either sign
            b = longint'(eig_thr) + $urandom_range(1);
            if ($urandom_range(1) == 1) b = -b;
            return b[31:0];
         end
         2: return $urandom;
         default: return pick_near(3 * longint'(eig_thr) + 3);
      endcase
   endfunction

   function automatic logic [15:0] pick_vec();
      case ($urandom_range(5))
         0: return 16'($urandom);   // any pattern, outside the unit range too
         1: return 16'($urandom_range(2) * Vec - Vec);   // -1, 0 or +1
         default: return 16'(pick_near(Vec));
      endcase
   endfunction

   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(5))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(262144);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      longint b;
      case ($urandom_range(7))
         0: begin
            px.grad_x = $urandom;
            px.grad_y = $urandom;
         end
         1: begin
            // magnitude right at the threshold or one lsb under it
            b = longint'(mag_thr) - $urandom_range(1);
            if ($urandom_range(1) == 1) b = -b;
            px.grad_x = b[31:0];
            px.grad_y = '0;
         end
         2: begin
            px.grad_x = '0;
            px.grad_y = '0;
         end
         default: begin
            px.grad_x = pick_near(2 * longint'(mag_thr) + 2);
            px.grad_y = pick_near(2 * longint'(mag_thr) + 2);
         end
      endcase
      px.eig_first    = pick_eigen();
      px.eig_second   = pick_eigen();
      px.vec_first_x  = pick_vec();
      px.vec_first_y  = pick_vec();
      px.vec_second_x = pick_vec();
      px.vec_second_y = pick_vec();
      return px;
   endfunction

   // -------------------------------------------------------------------------
   // channel drivers
   // -------------------------------------------------------------------------
   task automatic offer_pixel(input pixel_type px, input surface_label_type label);
      int unsigned gap;
      req_tdata  <= px;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_labels = {pending_labels, label};
      pixels_sent++;
      // bursts of random length, random idle gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(32, 1);
         gap        = $urandom_range(max_gap);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_threshold(input logic [CsrIdxW-1:0] idx,
                                  input logic [CsrDataW-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CsrGradMagThr: mag_thr  = value[ThrWidth-1:0];
         CsrEigenThr:   eig_thr  = value[ThrWidth-1:0];
         CsrProjThr:    proj_thr = value[ThrWidth-1:0];
         default: ;   // unused index, nothing changes
      endcase
   endtask

   // sender stops and waits for every queued label, plus pipeline slack
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // directed table: label classes and threshold edges at reset thresholds
   // rows with typed = 0 take their label from the predictor
   // -------------------------------------------------------------------------
   typedef struct packed {
      logic signed [31:0] gx, gy, e1, e2;
      logic signed [15:0] v1x, v1y, v2x, v2y;
      logic               typed;
      surface_label_type  label;
   } dir_row_type;

   dir_row_type dir_table [0:DirRows-1] = '{
      // flat ground
      '{0, 0, 0, 0, Vec, 0, 0, Vec, 1'b1, LBL_FLAT},
      '{0, 0, -Two, -Two, Vec, 0, 0, Vec, 1'b1, LBL_PEAK},
      '{0, 0, Two, Two, Vec, 0, 0, Vec, 1'b1, LBL_PIT},
      '{0, 0, Two, -2*Two, Vec, 0, 0, Vec, 1'b1, LBL_RIDGE_SADDLE},
      '{0, 0, 2*Two, -Two, Vec, 0, 0, Vec, 1'b1, LBL_RAVINE_SADDLE},
      // eigenvalues cancel, sum is zero so ravine side
      '{0, 0, Two, -Two, Vec, 0, 0, Vec, 1'b1, LBL_RAVINE_SADDLE},
      '{0, 0, -Two, 0, Vec, 0, 0, Vec, 1'b1, LBL_RIDGE},
      '{0, 0, 0, Two, Vec, 0, 0, Vec, 1'b1, LBL_RAVINE},
      // eigenvalues exactly on -threshold still count as flat
      '{0, 0, -One, -One, Vec, 0, 0, Vec, 1'b1, LBL_FLAT},
      '{0, 0, -One-1, -One-1, Vec, 0, 0, Vec, 1'b1, LBL_PEAK},
      // gradient one lsb under and exactly at the magnitude limit
      '{91749, 0, 0, 0, Vec, 0, 0, Vec, 1'b1, LBL_FLAT},
      '{91750, 0, 0, 0, Vec, 0, 0, Vec, 1'b1, LBL_SLOPE_HILL},
      // hill with one zero eigenvalue, the edge of the sign sub-cases, then both hill saddles
      '{Two, 0, Two, 0, Vec, 0, 0, Vec, 1'b1, LBL_CONVEX},
      '{0, Two, 0, -Two, Vec, 0, 0, Vec, 1'b1, LBL_CONCAVE},
      '{Two, Two, Two, -2*Two, Vec, 0, 0, Vec, 1'b1, LBL_CONVEX_SADDLE},
      '{Two, -Two, 2*Two, -Two, Vec, 0, 0, Vec, 1'b1, LBL_CONCAVE_SADDLE},
      // full-scale fields
      '{GMin, GMin, GMin, GMin, -Vec, -Vec, -Vec, -Vec, 1'b0, LBL_UNKNOWN},
      '{GMax, GMax, GMax, GMax, Vec, Vec, Vec, Vec, 1'b0, LBL_UNKNOWN},
      // eigenvectors outside the unit range go in unclamped
      '{Two, -Two, Two, -One, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
        1'b0, LBL_UNKNOWN},
      '{GMin, GMax, 0, GMin, 0, Vec, Vec, 0, 1'b0, LBL_UNKNOWN},
      '{0, 0, GMax, GMin, Vec, 0, 0, Vec, 1'b0, LBL_UNKNOWN},
      '{Two, Two, One/2, -One/2, Vec, 0, 0, Vec, 1'b0, LBL_UNKNOWN}
   };

   // -------------------------------------------------------------------------
   // sink: stretches of varying stall rate, including zero; one long hold-off
   // -------------------------------------------------------------------------
   initial begin : sink_pace
      int unsigned stretch, stall_pct;
      forever begin
         stretch = $urandom_range(120, 10);
         case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 60;
            default: stall_pct = 90;
         endcase
         repeat (stretch) begin
            @(posedge clock);
            if (long_hold_req) begin
               // hold off long enough for the pipeline and skid to back up
               rsp_tready <= 1'b0;
               repeat (HoldCycles) @(posedge clock);
               long_hold_req = 1'b0;
            end
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // label checker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : label_check
      surface_label_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_labels.size() == 0) begin
            $display("%0t: unexpected label beat, expected none, actual %0d",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_labels.pop_front();
            labels_checked++;
            if (rsp_tdata[3:0] <= LBL_UNKNOWN) label_hits[rsp_tdata[3:0]]++;
            if (rsp_tdata[3:0] !== want) begin
               $display("%0t: surface_label mismatch, expected %0d (%s), actual %0d",
                        $time, want, want.name(), rsp_tdata[3:0]);
               mismatch_count++;
            end
            if (rsp_tdata[RspDataW-1:4] !== '0) begin
               $display("%0t: label padding mismatch, expected 0, actual %0h",
                        $time, rsp_tdata[RspDataW-1:4]);
               mismatch_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      pixel_type         px;
      dir_row_type       row;
      surface_label_type lbl;
      string             mix;

      foreach (label_hits[i]) label_hits[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed rows under the reset thresholds
      for (int i = 0; i < DirRows; i++) begin
         row = dir_table[i];
         px.grad_x       = row.gx;
         px.grad_y       = row.gy;
         px.eig_first    = row.e1;
         px.eig_second   = row.e2;
         px.vec_first_x  = row.v1x;
         px.vec_first_y  = row.v1y;
         px.vec_second_x = row.v2x;
         px.vec_second_y = row.v2y;
         offer_pixel(px, row.typed ? row.label : classify_pixel(px));
      end
      drain_pipe();

      // random pixels under a series of threshold settings; the pipeline is
      // empty before every csr write
      for (int phase = 0; phase < NumPhases; phase++) begin
         case (phase)
            0: begin
               write_threshold(CsrGradMagThr, '0);
               write_threshold(CsrEigenThr, '0);
               write_threshold(CsrProjThr, '0);
            end
            1: begin
               // top bit is not part of the register, rest saturates to max
               write_threshold(CsrGradMagThr, 32'hFFFF_FFFF);
               write_threshold(CsrEigenThr, 32'hFFFF_FFFF);
               write_threshold(CsrProjThr, 32'hFFFF_FFFF);
            end
            2: begin
               write_threshold(CsrGradMagThr, {1'b1, GradMagThrReset});
               write_threshold(CsrEigenThr, {1'b1, EigenThrReset});
               write_threshold(CsrProjThr, {1'b1, ProjThrReset});
            end
            default: begin
               write_threshold(CsrGradMagThr, pick_threshold());
               write_threshold(CsrEigenThr, pick_threshold());
               write_threshold(CsrProjThr, pick_threshold());
            end
         endcase
         // must not disturb any threshold
         write_threshold(CsrUnused, $urandom);

         // every third phase runs the sender without gaps
         max_gap = (phase % 3 == 0) ? 0 : 8;
         if (phase == HoldPhase) long_hold_req = 1'b1;

         for (int n = 0; n < PhaseItems; n++) begin
            px = random_pixel();
            offer_pixel(px, classify_pixel(px));
         end
         drain_pipe();
      end

      for (int i = 0; i <= LBL_UNKNOWN; i++) begin
         lbl = surface_label_type'(i);
         mix = {mix, $sformatf(" %s=%0d", lbl.name(), label_hits[i])};
      end
      $display("%0d pixels labeled, %0d labels checked, %0d threshold settings",
               pixels_sent, labels_checked, NumPhases + 1);
      $display("label mix:%s", mix);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin : run_limit
      #800_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> files.f
src/tpc_pkg.sv
src/tpc_skid.sv
src/tpc_mult.sv
src/tpc_reduce.sv
src/tpc_label.sv
src/topographic_pixel_classifier.sv
bench/tb_topographic_pixel_classifier.sv
